@@ hw/rtl/crrqp_pkg.sv @@
// Shared constants, codes and control/status types of the credit round-robin queue picker.
package crrqp_pkg;

	localparam int unsigned DEF_MAX_QUEUES  = 64;
	localparam int unsigned DEF_CREDIT_BITS = 16;

	// Queues examined per leaf of the registered search tree
	localparam int unsigned GROUP_SIZE = 8;

	localparam int unsigned CMD_W      = 2;
	localparam int unsigned QIDX_W     = 6;
	localparam int unsigned SIZE_W     = 16;
	localparam int unsigned LEN_W      = 32;
	localparam int unsigned CODE_W     = 8;
	localparam int unsigned OUTCOME_W  = 3;
	localparam int unsigned CREDOUT_W  = 16;
	localparam int unsigned NQ_W       = 7;
	localparam int unsigned RESERVE_W  = 16;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CMD_W-1:0] CMD_INIT     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ACQUIRE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_COMPLETE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NONE     = 2'd3;

	localparam logic [OUTCOME_W-1:0] OUT_GRANTED   = 3'd0;
	localparam logic [OUTCOME_W-1:0] OUT_BAD_LEN   = 3'd1;
	localparam logic [OUTCOME_W-1:0] OUT_NO_CREDIT = 3'd2;
	localparam logic [OUTCOME_W-1:0] OUT_PENDING   = 3'd3;
	localparam logic [OUTCOME_W-1:0] OUT_DONE_OK   = 3'd4;
	localparam logic [OUTCOME_W-1:0] OUT_DONE_FAIL = 3'd5;
	localparam logic [OUTCOME_W-1:0] OUT_LOADED    = 3'd6;

	localparam logic [CODE_W-1:0] CODE_NONE = 8'd0;
	localparam logic [CODE_W-1:0] CODE_OK   = 8'd1;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_QUEUES   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_RESERVE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TRANSFER = 2'd2;

	localparam logic [NQ_W-1:0]       NUM_QUEUES_RST   = 7'd1;
	localparam logic [RESERVE_W-1:0]  SYNC_RESERVE_RST = 16'd16;
	localparam logic [LEN_W-1:0]      MAX_TRANSFER_RST = 32'h8000_0000;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic init_wr;
		logic bad_emit;
		logic mod_load;
		logic mod_step;
		logic srch1;
		logic srch2;
		logic rd_comp;
		logic rd_grant;
		logic wb_comp;
		logic wb_grant;
		logic no_credit;
	} crrqp_ctrl_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             len_bad;
		logic             ptr_wrap;
		logic             mod_last;
		logic             found;
	} crrqp_stat_t;

endpackage

@@ hw/rtl/credit_round_robin_queue_picker.sv @@
// Top level of the credit round-robin queue picker.
// A request is taken at a clock edge with start high and busy low, and its single result
// appears on outcome, granted_queue and credits_left for exactly one cycle with done high;
// the receiver cannot stall it. Requests are handled one at a time. A completion report
// reads the entry, then writes it back on the credit RAM. An acquire runs a length check
// (a failure ends it), two registered levels of the round-robin search over groups of eight
// queues (no credit found ends it), a RAM read and the decrement write-back. When the
// rotation pointer lies at or above the queue count (after num_queues has been lowered)
// an acquire runs the bit-serial remainder before the search. Command code 3 is taken and
// dropped without a result. Configuration writes go straight to the registers and must
// come while idle.
module credit_round_robin_queue_picker import crrqp_pkg::*; #(
	parameter int unsigned MAX_QUEUES  = DEF_MAX_QUEUES,
	parameter int unsigned CREDIT_BITS = DEF_CREDIT_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [CMD_W-1:0]      cmd,
	input  logic [QIDX_W-1:0]     queue_index,
	input  logic [SIZE_W-1:0]     queue_size,
	input  logic [LEN_W-1:0]      xfer_length,
	input  logic [CODE_W-1:0]     completion_code,
	output logic                  done,
	output logic [OUTCOME_W-1:0]  outcome,
	output logic [QIDX_W-1:0]     granted_queue,
	output logic [CREDOUT_W-1:0]  credits_left,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	crrqp_ctrl_t ctl;
	crrqp_stat_t sts;

	crrqp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	crrqp_datapath #(
		.MAX_QUEUES  (MAX_QUEUES),
		.CREDIT_BITS (CREDIT_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.sts             (sts),
		.cmd             (cmd),
		.queue_index     (queue_index),
		.queue_size      (queue_size),
		.xfer_length     (xfer_length),
		.completion_code (completion_code),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.done            (done),
		.outcome         (outcome),
		.granted_queue   (granted_queue),
		.credits_left    (credits_left)
	);

endmodule

@@ hw/rtl/crrqp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module crrqp_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 64
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/crrqp_ctrl.sv @@
// Controller state machine of the credit round-robin queue picker.
module crrqp_ctrl import crrqp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CMD_W-1:0] cmd,
	input  crrqp_stat_t      sts,
	output crrqp_ctrl_t      ctl,
	output logic             busy
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MOD,
		ST_SRCH1,
		ST_SRCH2,
		ST_PICK,
		ST_WB_GRANT,
		ST_WB_COMP
	} state_t;

	state_t state_q, state_d;
	logic   busy_q;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					// an unused command is taken and dropped
					if (cmd != CMD_NONE) begin
						state_d = ST_DECODE;
					end
				end
			end
			ST_DECODE: begin
				unique case (sts.cmd)
					CMD_INIT: begin
						ctl.init_wr = 1'b1;
						state_d     = ST_IDLE;
					end
					CMD_ACQUIRE: begin
						if (sts.len_bad) begin
							ctl.bad_emit = 1'b1;
							state_d      = ST_IDLE;
						end else begin
							ctl.mod_load = 1'b1;
							state_d      = sts.ptr_wrap ? ST_MOD : ST_SRCH1;
						end
					end
					CMD_COMPLETE: begin
						ctl.rd_comp = 1'b1;
						state_d     = ST_WB_COMP;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_MOD: begin
				ctl.mod_step = 1'b1;
				if (sts.mod_last) begin
					state_d = ST_SRCH1;
				end
			end
			ST_SRCH1: begin
				ctl.srch1 = 1'b1;
				state_d   = ST_SRCH2;
			end
			ST_SRCH2: begin
				ctl.srch2 = 1'b1;
				state_d   = ST_PICK;
			end
			ST_PICK: begin
				if (sts.found) begin
					ctl.rd_grant = 1'b1;
					state_d      = ST_WB_GRANT;
				end else begin
					ctl.no_credit = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_WB_GRANT: begin
				ctl.wb_grant = 1'b1;
				state_d      = ST_IDLE;
			end
			ST_WB_COMP: begin
				ctl.wb_comp = 1'b1;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != ST_IDLE);
		end
	end

	assign busy = busy_q;

endmodule

@@ hw/rtl/crrqp_datapath.sv @@
// Datapath: configuration, credit store, pointer remainder unit, search tree and result registers.
module crrqp_datapath import crrqp_pkg::*; #(
	parameter int unsigned MAX_QUEUES  = DEF_MAX_QUEUES,
	parameter int unsigned CREDIT_BITS = DEF_CREDIT_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  crrqp_ctrl_t           ctl,
	output crrqp_stat_t           sts,
	input  logic [CMD_W-1:0]      cmd,
	input  logic [QIDX_W-1:0]     queue_index,
	input  logic [SIZE_W-1:0]     queue_size,
	input  logic [LEN_W-1:0]      xfer_length,
	input  logic [CODE_W-1:0]     completion_code,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  done,
	output logic [OUTCOME_W-1:0]  outcome,
	output logic [QIDX_W-1:0]     granted_queue,
	output logic [CREDOUT_W-1:0]  credits_left
);

	localparam int unsigned QW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
	localparam int unsigned NW = $clog2(MAX_QUEUES + 1);
	localparam int unsigned CW = (NW > NQ_W) ? NW : NQ_W;
	localparam int unsigned NG = (MAX_QUEUES + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int unsigned OW = $clog2(GROUP_SIZE);
	localparam int unsigned GW = (NG > 1) ? $clog2(NG) : 1;
	localparam int unsigned XW = GW + OW;
	localparam int unsigned SW = (SIZE_W > CREDIT_BITS) ? SIZE_W : CREDIT_BITS;
	localparam int unsigned BW = (QW > 1) ? $clog2(QW) : 1;
	localparam logic [CREDIT_BITS-1:0] CREDIT_MAX = '1;

	// configuration
	logic [NQ_W-1:0]      num_queues_q;
	logic [RESERVE_W-1:0] sync_reserve_q;
	logic [LEN_W-1:0]     max_transfer_q;

	// latched request
	logic [CMD_W-1:0]  cmd_q;
	logic [QIDX_W-1:0] qidx_q;
	logic [SIZE_W-1:0] size_q;
	logic [LEN_W-1:0]  len_q;
	logic [CODE_W-1:0] code_q;

	// rotation and remainder unit
	logic [QW-1:0] ptr_q;
	logic [QW-1:0] start_q;
	logic [NW-1:0] rem_q;
	logic [QW-1:0] sh_q;
	logic [BW-1:0] bit_cnt_q;

	// nonzero flag per queue, cleared at reset and updated on every write
	logic [MAX_QUEUES-1:0] nz_q;

	// search tree
	logic [NG*GROUP_SIZE-1:0] req_all, req_hi;
	logic [NG-1:0]            any_all_c, any_hi_c, any_all_s1, any_hi_s1;
	logic [OW-1:0]            off_all_c [NG];
	logic [OW-1:0]            off_hi_c  [NG];
	logic [OW-1:0]            off_all_s1 [NG];
	logic [OW-1:0]            off_hi_s1  [NG];
	logic                     found_c, found_s2;
	logic [XW-1:0]            sel_c;
	logic [QW-1:0]            grant_s2;

	// credit store access
	logic                   ram_we;
	logic [QW-1:0]          ram_waddr, ram_raddr, rd_idx_q;
	logic [CREDIT_BITS-1:0] ram_wdata, ram_rdata;

	logic [CW-1:0]          nq_ext;
	logic [NW-1:0]          n_eff;
	logic                   q_in_store;
	logic [QW-1:0]          q_addr;
	logic [SW-1:0]          diff_w;
	logic [CREDIT_BITS-1:0] init_cred, rd_credit, comp_cred, grant_cred;
	logic [NW:0]            mod_t, mod_red;
	logic [NW:0]            ptr_next;
	logic [OUTCOME_W-1:0]   comp_outcome;

	logic                 done_q;
	logic [OUTCOME_W-1:0] outcome_q;
	logic [QIDX_W-1:0]    gq_q;
	logic [CREDOUT_W-1:0] cl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_queues_q   <= NUM_QUEUES_RST;
			sync_reserve_q <= SYNC_RESERVE_RST;
			max_transfer_q <= MAX_TRANSFER_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUM_QUEUES:   num_queues_q   <= cfg_data[NQ_W-1:0];
				REG_SYNC_RESERVE: sync_reserve_q <= cfg_data[RESERVE_W-1:0];
				REG_MAX_TRANSFER: max_transfer_q <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= cmd;
			qidx_q <= queue_index;
			size_q <= queue_size;
			len_q  <= xfer_length;
			code_q <= completion_code;
		end
	end

	// clamp the queue count into 1..MAX_QUEUES
	assign nq_ext = CW'(num_queues_q);
	always_comb begin
		if (nq_ext == '0) begin
			n_eff = NW'(1);
		end else if (nq_ext > CW'(MAX_QUEUES)) begin
			n_eff = NW'(MAX_QUEUES);
		end else begin
			n_eff = NW'(nq_ext);
		end
	end

	assign q_in_store = (32'(qidx_q) < 32'(MAX_QUEUES));
	assign q_addr     = QW'(qidx_q);

	always_comb begin
		if (size_q > sync_reserve_q) begin
			diff_w = SW'(size_q - sync_reserve_q);
		end else begin
			diff_w = SW'(1);
		end
		if (diff_w > SW'(CREDIT_MAX)) begin
			init_cred = CREDIT_MAX;
		end else begin
			init_cred = CREDIT_BITS'(diff_w);
		end
	end

	// an entry never written reads as zero credit
	assign rd_credit  = nz_q[rd_idx_q] ? ram_rdata : '0;
	assign comp_cred  = (code_q != CODE_NONE && rd_credit != CREDIT_MAX) ?
			rd_credit + CREDIT_BITS'(1) : rd_credit;
	assign grant_cred = rd_credit - CREDIT_BITS'(1);

	always_comb begin
		if (code_q == CODE_NONE) begin
			comp_outcome = OUT_PENDING;
		end else if (code_q == CODE_OK) begin
			comp_outcome = OUT_DONE_OK;
		end else begin
			comp_outcome = OUT_DONE_FAIL;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = q_addr;
		ram_wdata = init_cred;
		if (ctl.init_wr) begin
			ram_we = q_in_store;
		end
		if (ctl.wb_comp) begin
			ram_we    = q_in_store;
			ram_waddr = rd_idx_q;
			ram_wdata = comp_cred;
		end
		if (ctl.wb_grant) begin
			ram_we    = 1'b1;
			ram_waddr = rd_idx_q;
			ram_wdata = grant_cred;
		end
	end

	assign ram_raddr = ctl.rd_grant ? grant_s2 : q_addr;

	crrqp_ram #(
		.WIDTH (CREDIT_BITS),
		.DEPTH (MAX_QUEUES)
	) u_credit_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (ctl.rd_comp || ctl.rd_grant) begin
			rd_idx_q <= ram_raddr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nz_q <= '0;
		end else if (ram_we) begin
			nz_q[ram_waddr] <= (ram_wdata != '0);
		end
	end

	// restoring remainder of the pointer by the queue count, one bit a cycle
	assign mod_t   = {rem_q, sh_q[QW-1]};
	assign mod_red = (mod_t >= (NW+1)'(n_eff)) ? mod_t - (NW+1)'(n_eff) : mod_t;
	assign ptr_next = (NW+1)'(start_q) + (NW+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (ctl.srch1) begin
			// advance the pointer, wrap at the queue count
			ptr_q <= (ptr_next == (NW+1)'(n_eff)) ? '0 : QW'(ptr_next);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mod_load) begin
			start_q   <= ptr_q;
			rem_q     <= '0;
			sh_q      <= ptr_q;
			bit_cnt_q <= BW'(QW - 1);
		end else if (ctl.mod_step) begin
			rem_q     <= NW'(mod_red);
			sh_q      <= sh_q << 1;
			bit_cnt_q <= bit_cnt_q - BW'(1);
			if (bit_cnt_q == '0) begin
				start_q <= QW'(mod_red);
			end
		end
	end

	// leaf level: per group, any request and lowest requesting offset
	always_comb begin
		req_all = '0;
		req_hi  = '0;
		for (int i = 0; i < MAX_QUEUES; i++) begin
			req_all[i] = nz_q[i] && (NW'(i) < n_eff);
			req_hi[i]  = req_all[i] && (QW'(i) >= start_q);
		end
	end

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			any_all_c[g] = 1'b0;
			any_hi_c[g]  = 1'b0;
			off_all_c[g] = '0;
			off_hi_c[g]  = '0;
			for (int k = GROUP_SIZE - 1; k >= 0; k--) begin
				if (req_all[g*GROUP_SIZE + k]) begin
					any_all_c[g] = 1'b1;
					off_all_c[g] = OW'(k);
				end
				if (req_hi[g*GROUP_SIZE + k]) begin
					any_hi_c[g] = 1'b1;
					off_hi_c[g] = OW'(k);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.srch1) begin
			any_all_s1 <= any_all_c;
			any_hi_s1  <= any_hi_c;
			off_all_s1 <= off_all_c;
			off_hi_s1  <= off_hi_c;
		end
	end

	// root level: queues from the start onward first, then wrap to the lowest
	always_comb begin
		found_c = 1'b0;
		sel_c   = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (|any_hi_s1) begin
				if (any_hi_s1[g]) begin
					found_c = 1'b1;
					sel_c   = {GW'(g), off_hi_s1[g]};
				end
			end else if (any_all_s1[g]) begin
				found_c = 1'b1;
				sel_c   = {GW'(g), off_all_s1[g]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.srch2) begin
			found_s2 <= found_c;
			grant_s2 <= QW'(sel_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.init_wr || ctl.bad_emit || ctl.no_credit ||
					ctl.wb_comp || ctl.wb_grant;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.init_wr) begin
			outcome_q <= OUT_LOADED;
			gq_q      <= qidx_q;
			cl_q      <= q_in_store ? CREDOUT_W'(init_cred) : '0;
		end else if (ctl.bad_emit) begin
			outcome_q <= OUT_BAD_LEN;
			gq_q      <= '0;
			cl_q      <= '0;
		end else if (ctl.no_credit) begin
			outcome_q <= OUT_NO_CREDIT;
			gq_q      <= '0;
			cl_q      <= '0;
		end else if (ctl.wb_comp) begin
			outcome_q <= comp_outcome;
			gq_q      <= qidx_q;
			cl_q      <= q_in_store ? CREDOUT_W'(comp_cred) : '0;
		end else if (ctl.wb_grant) begin
			outcome_q <= OUT_GRANTED;
			gq_q      <= QIDX_W'(rd_idx_q);
			cl_q      <= CREDOUT_W'(grant_cred);
		end
	end

	assign sts.cmd      = cmd_q;
	assign sts.len_bad  = (len_q == '0) || (len_q > max_transfer_q);
	assign sts.ptr_wrap = (NW'(ptr_q) >= n_eff);
	assign sts.mod_last = (bit_cnt_q == '0);
	assign sts.found    = found_s2;

	assign done          = done_q;
	assign outcome       = outcome_q;
	assign granted_queue = gq_q;
	assign credits_left  = cl_q;

endmodule

@@ hw/rtl/crrqp_checker.sv @@
// Port-level checker for the credit round-robin queue picker, bound to the top level.
module crrqp_checker import crrqp_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic [CMD_W-1:0]      cmd,
	input logic                  done,
	input logic [OUTCOME_W-1:0]  outcome,
	input logic [QIDX_W-1:0]     granted_queue,
	input logic [CREDOUT_W-1:0]  credits_left
);

	// a request with a real command holds the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd != CMD_NONE |=> busy)
		else $error("request accepted but block not busy");

	// a result closes a busy period
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a request in flight");

	// one result per request, never two in a row
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// rejected and starved acquires carry no queue or credit
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (outcome == OUT_BAD_LEN || outcome == OUT_NO_CREDIT) |->
			granted_queue == '0 && credits_left == '0)
		else $error("rejected acquire reports a queue or credit");

	// outcome stays within the defined codes
	a_outcome_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> outcome <= OUT_LOADED)
		else $error("undefined outcome code");

endmodule

bind credit_round_robin_queue_picker crrqp_checker u_checker (.*);
